@@ rtl/core/lbwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lbwd_pkg
// Shared types and codes for the least-busy worker dispatcher: command and
// event codes, the widths of the fixed fields and the per-entry status word.
// ----------------------------------------------------------------------------
package lbwd_pkg;

    localparam int CMD_W  = 3;
    localparam int KEY_W  = 33;
    localparam int ADDR_W = 32;
    localparam int BUSY_W = 7;
    localparam int EV_W   = 4;
    localparam int WIDX_W = 4;

    localparam logic [BUSY_W-1:0] BUSY_MAX         = 7'd127;
    localparam logic [BUSY_W-1:0] BUSY_LIMIT_RESET = 7'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER   = 3'd0,
        CMD_RESULT     = 3'd1,
        CMD_PONG       = 3'd2,
        CMD_UNREGISTER = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_DISPATCH   = 3'd5
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_IGNORED      = 4'd0,
        EV_REGISTERED   = 4'd1,
        EV_FULL         = 4'd2,
        EV_RESULT       = 4'd3,
        EV_PONG         = 4'd4,
        EV_DISCONNECTED = 4'd5,
        EV_PING         = 4'd6,
        EV_DISPATCHED   = 4'd7,
        EV_NO_WORKER    = 4'd8
    } event_t;

    typedef struct packed {
        logic [BUSY_W-1:0] busy;
        logic              ping;
        logic              gone;
    } stat_t;

endpackage

@@ rtl/core/lbwd_ram.sv @@
// ----------------------------------------------------------------------------
// lbwd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/least_busy_worker_dispatcher_core.sv @@
// ----------------------------------------------------------------------------
// least_busy_worker_dispatcher_core
// Worker table with register/result/pong/unregister lookup, heartbeat tick
// and least-busy dispatch, held in a key RAM and a status RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command word per valid/ready handshake. m_* returns the
//   event words it causes; m_last marks the final word of a command. A tick
//   returns one word per live worker (one IGNORED if none), others one.
//   cfg_we/cfg_wdata load busy_limit; write it only while the block is idle.
// Command flow:
//   register and commands that need no scan skip the walk and go to EMIT.
//   Lookup, tick and dispatch walk the table one entry per cycle through the
//   RAM read port, a tick only while its output does not stall; a lookup
//   stops at its match and a dispatch at the first idle worker.
//   A new command is taken once the previous one has placed its last word in
//   the output register.
// Reset:
//   aresetn clears the entry count and sets busy_limit to 100. RAM contents
//   are not cleared; entries at or above the count are never used.
// Stall:
//   a held m_valid freezes the tick walk on the next live entry; the output
//   register still lets the next command in while the final word waits.
// ----------------------------------------------------------------------------
module least_busy_worker_dispatcher_core #(
    parameter int MAX_WORKERS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [lbwd_pkg::BUSY_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lbwd_pkg::CMD_W-1:0]   s_command,
    input  logic                         s_address_family,
    input  logic [lbwd_pkg::ADDR_W-1:0]  s_address_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lbwd_pkg::EV_W-1:0]    m_event_res,
    output logic [lbwd_pkg::WIDX_W-1:0]  m_worker_index,
    output logic                         m_last
);

    import lbwd_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORKERS);
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int STAT_W = $bits(stat_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORKERS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BUSY_W-1:0]    limit_reg, limit_next;
    logic                 best_found_reg, best_found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [BUSY_W-1:0]    best_busy_reg, best_busy_next;
    logic                 best_ping_reg, best_ping_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [EV_W-1:0]      pend_ev_reg, pend_ev_next;
    logic [WIDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [EV_W-1:0]      m_ev_reg, m_ev_next;
    logic [WIDX_W-1:0]    m_idx_reg, m_idx_next;
    logic                 m_last_reg, m_last_next;

    logic                 key_we, stat_we;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [KEY_W-1:0]     key_wdata, rd_key;
    stat_t                stat_wdata, rd_stat;

    logic                 out_free, push, push_last;
    logic [EV_W-1:0]      push_ev;
    logic [WIDX_W-1:0]    push_idx;
    logic                 live, match, at_end, stall, pick_idle;
    logic                 c_found, c_ping;
    logic [IDX_W-1:0]     c_idx;
    logic [BUSY_W-1:0]    c_busy;

    lbwd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_WORKERS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    lbwd_ram #(
        .WIDTH (STAT_W),
        .DEPTH (MAX_WORKERS)
    ) u_stat_ram (
        .aclk  (aclk),
        .we    (stat_we),
        .waddr (wr_addr),
        .wdata (stat_wdata),
        .raddr (rd_addr),
        .rdata (rd_stat)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign live     = !rd_stat.gone;
    assign match    = live && (rd_key == key_reg);
    assign at_end   = (CNT_W'(scan_reg) + CNT_W'(1)) == count_reg;
    assign stall    = live && pend_valid_reg && !out_free;
    assign pick_idle = live && (rd_stat.busy == '0);

    always_comb begin
        c_found = best_found_reg;
        c_idx   = best_idx_reg;
        c_busy  = best_busy_reg;
        c_ping  = best_ping_reg;
        if (pick_idle || (live && (rd_stat.busy < best_busy_reg))) begin
            c_found = 1'b1;
            c_idx   = scan_reg;
            c_busy  = rd_stat.busy;
            c_ping  = rd_stat.ping;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_busy_next  = best_busy_reg;
        best_ping_next  = best_ping_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_idx_next   = pend_idx_reg;
        key_we          = 1'b0;
        stat_we         = 1'b0;
        wr_addr         = scan_reg;
        key_wdata       = key_reg;
        stat_wdata      = rd_stat;
        rd_addr         = scan_reg;
        push            = 1'b0;
        push_ev         = pend_ev_reg;
        push_idx        = pend_idx_reg;
        push_last       = 1'b0;

        if (cfg_we) begin
            limit_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_command;
                    key_next        = {s_address_family, s_address_key};
                    scan_next       = '0;
                    rd_addr         = '0;
                    best_found_next = 1'b0;
                    best_busy_next  = limit_reg;
                    pend_valid_next = 1'b0;
                    pend_idx_next   = '0;
                    state_next      = ST_EMIT;
                    priority if (s_command == CMD_REGISTER) begin
                        if (count_reg == CNT_MAX) begin
                            pend_ev_next = EV_FULL;
                        end else begin
                            key_we        = 1'b1;
                            stat_we       = 1'b1;
                            wr_addr       = count_reg[IDX_W-1:0];
                            key_wdata     = {s_address_family, s_address_key};
                            stat_wdata    = '0;
                            count_next    = count_reg + CNT_W'(1);
                            pend_ev_next  = EV_REGISTERED;
                            pend_idx_next = WIDX_W'(count_reg[IDX_W-1:0]);
                        end
                    end else if (s_command == CMD_RESULT || s_command == CMD_PONG ||
                                 s_command == CMD_UNREGISTER || s_command == CMD_TICK ||
                                 s_command == CMD_DISPATCH) begin
                        if (count_reg == '0) begin
                            pend_ev_next = (s_command == CMD_DISPATCH) ? EV_NO_WORKER
                                                                       : EV_IGNORED;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else begin
                        pend_ev_next = EV_IGNORED;
                    end
                end
            end

            ST_SCAN: begin
                unique case (cmd_reg)
                    CMD_RESULT, CMD_PONG, CMD_UNREGISTER: begin
                        if (match) begin
                            stat_we       = 1'b1;
                            pend_idx_next = WIDX_W'(scan_reg);
                            state_next    = ST_EMIT;
                            if (cmd_reg == CMD_RESULT) begin
                                if (rd_stat.busy != '0) begin
                                    stat_wdata.busy = rd_stat.busy - BUSY_W'(1);
                                end
                                pend_ev_next = EV_RESULT;
                            end else if (cmd_reg == CMD_PONG) begin
                                stat_wdata.ping = 1'b0;
                                pend_ev_next    = EV_PONG;
                            end else begin
                                stat_wdata.gone = 1'b1;
                                pend_ev_next    = EV_DISCONNECTED;
                            end
                        end else if (at_end) begin
                            pend_ev_next  = EV_IGNORED;
                            pend_idx_next = '0;
                            state_next    = ST_EMIT;
                        end else begin
                            scan_next = scan_reg + IDX_W'(1);
                            rd_addr   = scan_reg + IDX_W'(1);
                        end
                    end

                    CMD_TICK: begin
                        if (!stall) begin
                            if (live) begin
                                stat_we         = 1'b1;
                                push            = pend_valid_reg;
                                pend_valid_next = 1'b1;
                                pend_idx_next   = WIDX_W'(scan_reg);
                                if (rd_stat.ping) begin
                                    stat_wdata.gone = 1'b1;
                                    pend_ev_next    = EV_DISCONNECTED;
                                end else begin
                                    stat_wdata.ping = 1'b1;
                                    pend_ev_next    = EV_PING;
                                end
                            end
                            if (at_end) begin
                                state_next = ST_EMIT;
                                if (!live && !pend_valid_reg) begin
                                    pend_ev_next  = EV_IGNORED;
                                    pend_idx_next = '0;
                                end
                            end else begin
                                scan_next = scan_reg + IDX_W'(1);
                                rd_addr   = scan_reg + IDX_W'(1);
                            end
                        end
                    end

                    CMD_DISPATCH: begin
                        if (pick_idle || at_end) begin
                            state_next = ST_EMIT;
                            if (c_found) begin
                                stat_we         = 1'b1;
                                wr_addr         = c_idx;
                                stat_wdata.busy = (c_busy < BUSY_MAX) ? c_busy + BUSY_W'(1)
                                                                      : c_busy;
                                stat_wdata.ping = c_ping;
                                stat_wdata.gone = 1'b0;
                                pend_ev_next    = EV_DISPATCHED;
                                pend_idx_next   = WIDX_W'(c_idx);
                            end else begin
                                pend_ev_next  = EV_NO_WORKER;
                                pend_idx_next = '0;
                            end
                        end else begin
                            best_found_next = c_found;
                            best_idx_next   = c_idx;
                            best_busy_next  = c_busy;
                            best_ping_next  = c_ping;
                            scan_next       = scan_reg + IDX_W'(1);
                            rd_addr         = scan_reg + IDX_W'(1);
                        end
                    end

                    default: begin
                        pend_ev_next  = EV_IGNORED;
                        pend_idx_next = '0;
                        state_next    = ST_EMIT;
                    end
                endcase
            end

            ST_EMIT: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        m_ev_next    = m_ev_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_ev_next    = push_ev;
            m_idx_next   = push_idx;
            m_last_next  = push_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            limit_reg      <= BUSY_LIMIT_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            limit_reg      <= limit_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_busy_reg  <= best_busy_next;
        best_ping_reg  <= best_ping_next;
        pend_ev_reg    <= pend_ev_next;
        pend_idx_reg   <= pend_idx_next;
        m_ev_reg       <= m_ev_next;
        m_idx_reg      <= m_idx_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_event_res    = m_ev_reg;
    assign m_worker_index = m_idx_reg;
    assign m_last         = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("entry count above table depth");

    a_tick_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmd_reg == CMD_TICK && stat_we && !at_end)
            |-> (rd_addr != wr_addr))
        else $error("tick walk reads the entry it writes");

    a_scan_word_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && push) |=> (m_valid && !m_last))
        else $error("tick word inside the walk marked last");

    a_register_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_REGISTER && count_reg != CNT_MAX)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("register did not append an entry");

    a_stall_holds_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmd_reg == CMD_TICK && stall)
            |=> (scan_reg == $past(scan_reg) && state_reg == ST_SCAN))
        else $error("tick walk advanced while output stalled");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the least-busy worker dispatcher core. A short
// table of directed commands covers the empty table, first-idle dispatch,
// unknown and duplicate keys and the full table. Random heartbeat rounds,
// dispatch and result traffic and noise follow under several busy limits.
// An in-bench model of the worker table predicts the event words of every
// untyped command, and both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbwd_pkg::*;

    localparam int MAX_WORKERS = 16;
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 72;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              fam;
        logic [ADDR_W-1:0] addr;
    } cmd_word_t;

    typedef struct {
        event_t            ev;
        logic [WIDX_W-1:0] idx;
        logic              last;
    } event_word_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic              fam;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        event_t            ev;
        logic [WIDX_W-1:0] idx;
    } probe_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [BUSY_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic                s_address_family;
    logic [ADDR_W-1:0]   s_address_key;
    logic                m_valid;
    logic                m_ready;
    logic [EV_W-1:0]     m_event_res;
    logic [WIDX_W-1:0]   m_worker_index;
    logic                m_last;

    logic [KEY_W-1:0]    wk_key  [MAX_WORKERS];
    logic [BUSY_W-1:0]   wk_busy [MAX_WORKERS];
    logic                wk_ping [MAX_WORKERS];
    logic                wk_gone [MAX_WORKERS];
    int                  wk_count;
    logic [BUSY_W-1:0]   wk_limit;

    event_word_t         step_events[$];
    event_word_t         pending_events[$];
    cmd_word_t           heartbeat_plan[$];
    int                  beats_to_tick;
    int                  fault_count;
    bit                  sender_idles;
    bit                  receiver_stalls;

    probe_row_t probes [27] = '{
        '{CMD_TICK,       1'b0, 32'h0000_0000, 1'b1, EV_IGNORED,      4'd0},
        '{CMD_DISPATCH,   1'b0, 32'h0000_0000, 1'b1, EV_NO_WORKER,    4'd0},
        '{CMD_PONG,       1'b1, 32'h1234_5678, 1'b1, EV_IGNORED,      4'd0},
        '{CMD_RSVD_A,     1'b0, 32'h0000_0000, 1'b1, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h0000_0000, 1'b1, EV_REGISTERED,   4'd0},
        '{CMD_REGISTER,   1'b1, 32'h0000_0000, 1'b1, EV_REGISTERED,   4'd1},
        '{CMD_REGISTER,   1'b0, 32'hFFFF_FFFF, 1'b1, EV_REGISTERED,   4'd2},
        '{CMD_REGISTER,   1'b1, 32'hFFFF_FFFF, 1'b1, EV_REGISTERED,   4'd3},
        '{CMD_REGISTER,   1'b0, 32'h0000_0000, 1'b1, EV_REGISTERED,   4'd4},
        '{CMD_RESULT,     1'b1, 32'h0000_0000, 1'b1, EV_RESULT,       4'd1},
        '{CMD_PONG,       1'b0, 32'hFFFF_FFFF, 1'b1, EV_PONG,         4'd2},
        '{CMD_DISPATCH,   1'b0, 32'h0000_0000, 1'b1, EV_DISPATCHED,   4'd0},
        '{CMD_UNREGISTER, 1'b0, 32'h0000_0000, 1'b1, EV_DISCONNECTED, 4'd0},
        '{CMD_RESULT,     1'b0, 32'h0000_0000, 1'b1, EV_RESULT,       4'd4},
        '{CMD_TICK,       1'b0, 32'h0000_0000, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h0000_0001, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'h8000_0000, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h5555_5555, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'hAAAA_AAAA, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h0F0F_F0F0, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'h1357_9BDF, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'hFEDC_BA98, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'h0000_8000, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h7FFF_FFFF, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'hC3C3_3C3C, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b0, 32'h0101_0101, 1'b0, EV_IGNORED,      4'd0},
        '{CMD_REGISTER,   1'b1, 32'h8000_0001, 1'b1, EV_FULL,         4'd0}
    };

    least_busy_worker_dispatcher_core #(
        .MAX_WORKERS(MAX_WORKERS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_address_family(s_address_family),
        .s_address_key   (s_address_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_worker_index  (m_worker_index),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void add_event(input event_t ev, input int idx);
        event_word_t w;
        w.ev   = ev;
        w.idx  = WIDX_W'(idx);
        w.last = 1'b0;
        step_events.push_back(w);
    endfunction

    function automatic int find_worker(input logic [KEY_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < wk_count; i++) begin
            if (hit < 0 && !wk_gone[i] && wk_key[i] == key) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    function automatic void apply_command(input cmd_word_t c);
        logic [KEY_W-1:0]  key;
        logic [BUSY_W-1:0] best_busy;
        int                hit;
        int                best;
        bit                idle_found;
        event_word_t       tail;
        key = {c.fam, c.addr};
        step_events.delete();
        case (c.cmd)
            CMD_REGISTER: begin
                if (wk_count >= MAX_WORKERS) begin
                    add_event(EV_FULL, 0);
                end else begin
                    wk_key[wk_count]  = key;
                    wk_busy[wk_count] = '0;
                    wk_ping[wk_count] = 1'b0;
                    wk_gone[wk_count] = 1'b0;
                    add_event(EV_REGISTERED, wk_count);
                    wk_count++;
                end
            end
            CMD_RESULT, CMD_PONG, CMD_UNREGISTER: begin
                hit = find_worker(key);
                if (hit < 0) begin
                    add_event(EV_IGNORED, 0);
                end else if (c.cmd == CMD_RESULT) begin
                    if (wk_busy[hit] != 0) wk_busy[hit] = wk_busy[hit] - 1'b1;
                    add_event(EV_RESULT, hit);
                end else if (c.cmd == CMD_PONG) begin
                    wk_ping[hit] = 1'b0;
                    add_event(EV_PONG, hit);
                end else begin
                    wk_gone[hit] = 1'b1;
                    add_event(EV_DISCONNECTED, hit);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < wk_count; i++) begin
                    if (!wk_gone[i]) begin
                        if (wk_ping[i]) begin
                            wk_gone[i] = 1'b1;
                            add_event(EV_DISCONNECTED, i);
                        end else begin
                            wk_ping[i] = 1'b1;
                            add_event(EV_PING, i);
                        end
                    end
                end
                if (step_events.size() == 0) add_event(EV_IGNORED, 0);
            end
            CMD_DISPATCH: begin
                best = -1;
                best_busy = wk_limit;
                idle_found = 1'b0;
                for (int i = 0; i < wk_count; i++) begin
                    if (!idle_found && !wk_gone[i]) begin
                        if (wk_busy[i] == 0) begin
                            best = i;
                            idle_found = 1'b1;
                        end else if (wk_busy[i] < best_busy) begin
                            best_busy = wk_busy[i];
                            best = i;
                        end
                    end
                end
                if (best < 0) begin
                    add_event(EV_NO_WORKER, 0);
                end else begin
                    if (wk_busy[best] < BUSY_MAX) wk_busy[best] = wk_busy[best] + 1'b1;
                    add_event(EV_DISPATCHED, best);
                end
            end
            default: add_event(EV_IGNORED, 0);
        endcase
        tail = step_events.pop_back();
        tail.last = 1'b1;
        step_events.push_back(tail);
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_live();
        int live[$];
        for (int i = 0; i < wk_count; i++) begin
            if (!wk_gone[i]) live.push_back(i);
        end
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic next_random(output cmd_word_t w);
        int        r;
        int        pick;
        cmd_word_t beat;
        if (heartbeat_plan.size() == 0) begin
            beats_to_tick--;
            if (beats_to_tick <= 0) begin
                beats_to_tick = $urandom_range(12, 40);
                for (int i = 0; i < wk_count; i++) begin
                    if (!wk_gone[i] && wk_ping[i] && $urandom_range(0, 99) < 97) begin
                        beat.cmd = CMD_PONG;
                        {beat.fam, beat.addr} = wk_key[i];
                        heartbeat_plan.push_back(beat);
                    end
                end
                beat.cmd  = CMD_TICK;
                beat.fam  = 1'($urandom);
                beat.addr = $urandom;
                heartbeat_plan.push_back(beat);
            end
        end
        if (heartbeat_plan.size() != 0) begin
            w = heartbeat_plan.pop_front();
            return;
        end
        r = $urandom_range(0, 99);
        pick = pick_live();
        w.cmd  = CMD_DISPATCH;
        w.fam  = 1'($urandom);
        w.addr = $urandom;
        if (r < 36) begin
            w.cmd = CMD_DISPATCH;
        end else if (r < 71) begin
            if (r < 60) w.cmd = CMD_RESULT;
            else if (r < 70) w.cmd = CMD_PONG;
            else w.cmd = CMD_UNREGISTER;
            if (pick >= 0) {w.fam, w.addr} = wk_key[pick];
        end else if (r < 74) begin
            w.cmd = CMD_REGISTER;
        end else if (r < 77) begin
            w.cmd = CMD_TICK;
        end else if (r < 82) begin
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_RSVD_A : CMD_RSVD_B;
        end else if (r < 92) begin
            w.cmd = ($urandom_range(0, 1) != 0) ? CMD_RESULT : CMD_PONG;
            if (wk_count > 0) begin
                {w.fam, w.addr} = wk_key[$urandom_range(0, wk_count - 1)];
                if ($urandom_range(0, 2) == 0) w.fam = ~w.fam;
            end
        end else begin
            case ($urandom_range(0, 2))
                0: w.cmd = CMD_RESULT;
                1: w.cmd = CMD_PONG;
                default: w.cmd = CMD_UNREGISTER;
            endcase
        end
    endtask

    task automatic issue(input cmd_word_t c, input bit typed, input event_t ev,
                         input logic [WIDX_W-1:0] idx);
        event_word_t want;
        int          gap;
        bit          drain;
        s_valid          <= 1'b1;
        s_command        <= c.cmd;
        s_address_family <= c.fam;
        s_address_key    <= c.addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(c);
        if (typed) begin
            want.ev   = ev;
            want.idx  = idx;
            want.last = 1'b1;
            pending_events.push_back(want);
        end else begin
            foreach (step_events[i]) pending_events.push_back(step_events[i]);
        end
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) >= 55) gap = idle_length();
        drain = ($urandom_range(0, 199) == 0);
        if (drain && gap == 0) gap = 1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if (drain) begin
                while (pending_events.size() != 0) @(posedge aclk);
            end
        end
    endtask

    task automatic write_busy_limit(input logic [BUSY_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        wk_limit = value;
    endtask

    initial begin : result_monitor
        int          stall_left;
        event_word_t want;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected word: ev=%0d idx=%0d last=%0b",
                                 m_event_res, m_worker_index, m_last);
                    end
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_res !== want.ev || m_worker_index !== want.idx ||
                        m_last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("mismatch: expected ev=%0d idx=%0d last=%0b, got ev=%0d idx=%0d last=%0b",
                                     want.ev, want.idx, want.last,
                                     m_event_res, m_worker_index, m_last);
                        end
                    end
                end
            end
            if (!receiver_stalls || !aresetn) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall_left = idle_length();
            end
        end
    end

    initial begin : stimulus
        cmd_word_t         c;
        logic [BUSY_W-1:0] limits [PHASES];
        fault_count      = 0;
        wk_count         = 0;
        wk_limit         = BUSY_LIMIT_RESET;
        beats_to_tick    = 4;
        sender_idles     = 1'b1;
        receiver_stalls  = 1'b1;
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_command        <= '0;
        s_address_family <= 1'b0;
        s_address_key    <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) begin
            c.cmd  = probes[i].cmd;
            c.fam  = probes[i].fam;
            c.addr = probes[i].addr;
            issue(c, probes[i].typed, probes[i].ev, probes[i].idx);
        end

        limits = '{7'd127, 7'd1, 7'd0, 7'd3, BUSY_W'($urandom_range(2, 126)), 7'd100};
        for (int p = 0; p < PHASES; p++) begin
            write_busy_limit(limits[p]);
            sender_idles    = (p != 3);
            receiver_stalls = (p != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                next_random(c);
                issue(c, 1'b0, EV_IGNORED, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (2 * MAX_WORKERS + 8) @(posedge aclk);
        if (fault_count == 0 && pending_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lbwd_pkg.sv
rtl/core/lbwd_ram.sv
rtl/core/least_busy_worker_dispatcher_core.sv
test/tb.sv
